### src/dlt_pkg.sv
// ============================================================================
// dlt_pkg
// Shared types and constants for the delimited-text line field tokenizer.
// ============================================================================
package dlt_pkg;

    // Line length limit; the line is truncated after offset MAX_LINE_BYTES-2
    localparam int MAX_LINE_BYTES = 65536;
    localparam logic [15:0] TRUNC_POS = 16'(MAX_LINE_BYTES - 2);

    localparam logic [7:0] QUOTE_BYTE = 8'h22;
    localparam logic [7:0] HASH_BYTE  = 8'h23;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_DELIMITER        = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_EXPECTED_COLUMNS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STOP_ON_COMMENT  = 2'd2;

    // Input item action
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_EOL  = 1'b1;

    // Result kind
    typedef enum logic [1:0] {
        KIND_FIELD        = 2'd0,
        KIND_LINE_DONE    = 2'd1,
        KIND_COMMENT_SKIP = 2'd2,
        KIND_COMMENT_STOP = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] column_number;
        logic [15:0] field_begin;
        logic [15:0] field_end;
        logic        parse_failed;
        logic        last;
    } result_t;

    // Results produced by one item, handed to the result queue
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

### src/dlt_parse.sv
// ============================================================================
// dlt_parse
// Input register, line state and per-byte tokenizing logic. Produces up to
// two results per item for the result queue.
// ============================================================================
module dlt_parse (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input beats
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            in_action,
    input  logic [7:0]                      in_byte,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [dlt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dlt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // result queue
    input  logic                            queue_room,
    output dlt_pkg::push_t                  push
);

    // input register
    logic        in_valid_reg;
    logic        in_action_reg;
    logic [7:0]  in_byte_reg;

    // configuration
    logic [7:0]  delim_reg;
    logic [15:0] exp_cols_reg;
    logic        stop_reg;

    // line state
    logic [15:0] byte_pos_reg,  byte_pos_next;
    logic [15:0] col_reg,       col_next;
    logic [15:0] begin_reg,     begin_next;
    logic [15:0] end_reg,       end_next;
    logic        inq_reg,       inq_next;
    logic        pend_reg,      pend_next;
    logic        closed_reg,    closed_next;
    logic        qallow_reg,    qallow_next;
    logic        trunc_reg,     trunc_next;
    logic        comment_reg,   comment_next;

    logic        fire;
    logic        escaped;
    logic        fail;
    logic [15:0] pos_inc;
    logic [16:0] col_plus;
    dlt_pkg::result_t field_res;
    dlt_pkg::result_t done_res;

    // item is processed once the queue can take two results
    assign fire     = in_valid_reg && queue_room;
    assign in_ready = !in_valid_reg || queue_room;

    assign pos_inc  = byte_pos_reg + 16'd1;
    assign col_plus = {1'b0, col_reg} + 17'd1;

    // next state and results
    always_comb begin
        byte_pos_next = byte_pos_reg;
        col_next      = col_reg;
        begin_next    = begin_reg;
        end_next      = end_reg;
        inq_next      = inq_reg;
        pend_next     = pend_reg;
        closed_next   = closed_reg;
        qallow_next   = qallow_reg;
        trunc_next    = trunc_reg;
        comment_next  = comment_reg;
        push          = '0;
        escaped       = 1'b0;

        field_res               = '0;
        field_res.kind          = dlt_pkg::KIND_FIELD;
        field_res.column_number = col_reg;
        field_res.field_begin   = begin_reg;
        field_res.field_end     = end_reg;

        fail = trunc_reg ||
               ((exp_cols_reg != 16'd0) && (col_plus != {1'b0, exp_cols_reg}));
        done_res               = '0;
        done_res.kind          = dlt_pkg::KIND_LINE_DONE;
        done_res.column_number = col_reg;
        done_res.parse_failed  = fail;
        done_res.last          = 1'b1;

        if (fire) begin
            if (in_action_reg == dlt_pkg::ACT_EOL) begin
                // end of line: report, then return to line start
                if (comment_reg) begin
                    push.count      = 2'd1;
                    push.first.kind = stop_reg ? dlt_pkg::KIND_COMMENT_STOP
                                               : dlt_pkg::KIND_COMMENT_SKIP;
                    push.first.last = 1'b1;
                end else if (begin_reg != end_reg) begin
                    push.count  = 2'd2;
                    push.first  = field_res;
                    push.second = done_res;
                end else begin
                    push.count = 2'd1;
                    push.first = done_res;
                end
                byte_pos_next = '0;
                col_next      = '0;
                begin_next    = '0;
                end_next      = '0;
                inq_next      = 1'b0;
                pend_next     = 1'b0;
                closed_next   = 1'b0;
                qallow_next   = 1'b1;
                trunc_next    = 1'b0;
                comment_next  = 1'b0;
            end else if (!comment_reg && !trunc_reg) begin
                if (byte_pos_reg == 16'd0 && in_byte_reg == dlt_pkg::HASH_BYTE) begin
                    comment_next = 1'b1;
                end else begin
                    // pending quote: escape or close
                    if (pend_reg) begin
                        pend_next = 1'b0;
                        if (in_byte_reg == dlt_pkg::QUOTE_BYTE) begin
                            escaped = 1'b1;
                        end else begin
                            inq_next    = 1'b0;
                            closed_next = 1'b1;
                        end
                    end
                    if (!escaped) begin
                        if (in_byte_reg == dlt_pkg::QUOTE_BYTE) begin
                            if (qallow_reg && !inq_next) begin
                                inq_next   = 1'b1;
                                begin_next = pos_inc;
                                end_next   = pos_inc;
                            end else if (inq_next) begin
                                pend_next = 1'b1;
                            end
                        end else if (!inq_next && in_byte_reg == delim_reg) begin
                            if (begin_reg != end_reg) begin
                                push.count      = 2'd1;
                                push.first      = field_res;
                                push.first.last = 1'b1;
                            end
                            closed_next = 1'b0;
                            qallow_next = 1'b1;
                            col_next    = col_reg + 16'd1;
                            begin_next  = pos_inc;
                            end_next    = pos_inc;
                        end else if (!closed_next) begin
                            qallow_next = 1'b0;
                            end_next    = pos_inc;
                        end
                    end
                    if (byte_pos_reg >= dlt_pkg::TRUNC_POS) begin
                        trunc_next = 1'b1;
                    end
                    byte_pos_next = pos_inc;
                end
            end
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            delim_reg    <= 8'd44;
            exp_cols_reg <= 16'd0;
            stop_reg     <= 1'b1;
            byte_pos_reg <= '0;
            col_reg      <= '0;
            begin_reg    <= '0;
            end_reg      <= '0;
            inq_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            closed_reg   <= 1'b0;
            qallow_reg   <= 1'b1;
            trunc_reg    <= 1'b0;
            comment_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    dlt_pkg::REG_DELIMITER:        delim_reg    <= cfg_wdata[7:0];
                    dlt_pkg::REG_EXPECTED_COLUMNS: exp_cols_reg <= cfg_wdata[15:0];
                    dlt_pkg::REG_STOP_ON_COMMENT:  stop_reg     <= cfg_wdata[0];
                    default: ;
                endcase
            end
            byte_pos_reg <= byte_pos_next;
            col_reg      <= col_next;
            begin_reg    <= begin_next;
            end_reg      <= end_next;
            inq_reg      <= inq_next;
            pend_reg     <= pend_next;
            closed_reg   <= closed_next;
            qallow_reg   <= qallow_next;
            trunc_reg    <= trunc_next;
            comment_reg  <= comment_next;
        end
    end

    // input payload
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            in_action_reg <= in_action;
            in_byte_reg   <= in_byte;
        end
    end

    // a comment line is never truncated
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(comment_reg && trunc_reg))
        else $error("comment and truncated both set");

    // a pending quote only exists inside a quoted field
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> inq_reg)
        else $error("pending quote outside quotes");

    // end of line returns the line state to its start
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_action_reg == dlt_pkg::ACT_EOL) |=>
            (byte_pos_reg == 16'd0 && col_reg == 16'd0 && qallow_reg && !comment_reg))
        else $error("line state not cleared at end of line");

endmodule

### src/dlt_out_fifo.sv
// ============================================================================
// dlt_out_fifo
// Four-entry result queue. Takes up to two results per cycle and presents
// one result beat per cycle on the output side while the receiver is ready.
// ============================================================================
module dlt_out_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  dlt_pkg::push_t    push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output dlt_pkg::result_t  out_data
);

    dlt_pkg::result_t mem_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg,  count_next;
    logic       pop;

    assign out_valid = count_reg != 3'd0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // space for the worst case of two results
    assign room      = count_reg <= 3'd2;

    // pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.count} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_reg + 2'd1] <= push.second;
        end
    end

endmodule

### src/dsv_line_field_tokenizer_core.sv
// ============================================================================
// dsv_line_field_tokenizer_core
// Delimited-text line tokenizer with quoted fields, one byte per beat.
// ============================================================================
// Usage:
//   The slave channel carries one line byte per beat (s_tuser = 0) or an
//   end-of-line marker (s_tuser = 1). The master channel returns a result
//   per non-empty field (column, begin and end offset) when its delimiter
//   or the end of line arrives, and a line-done or comment result at end
//   of line. m_tlast marks the final result caused by one input beat.
//   Configuration (delimiter, expected column count, comment mode) is
//   written through cfg_wr_en/cfg_addr/cfg_wdata while the block is idle.
//   An accepted input beat is held in the input register, which feeds
//   the result queue directly; the queue then presents its results.
//   Throughput: one input beat per cycle while the queue has room. An end
//   of line that closes a field yields two result beats, so the output port
//   at one beat per cycle and the four-entry queue set the sustained rate.
//   Reset (aresetn low, synchronous) restores the register defaults,
//   clears the line state and empties the queue.
//   When the receiver stalls, results wait in the queue; input keeps being
//   accepted while the queue has room for two more results.
// ============================================================================
module dsv_line_field_tokenizer_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] byte_value
    input  logic [0:0]                      s_tuser,   // [0] action
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] column_number, [31:16] field_begin, [47:32] field_end,
    // [48] parse_failed, [55:49] zero
    output logic [55:0]                     m_tdata,
    output logic [1:0]                      m_tuser,   // [1:0] kind
    output logic                            m_tlast,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [dlt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dlt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    dlt_pkg::push_t   push;
    dlt_pkg::result_t head;
    logic             queue_room;

    dlt_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (s_tuser[0]),
        .in_byte    (s_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .queue_room (queue_room),
        .push       (push)
    );

    dlt_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (queue_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    // result beat packing
    assign m_tdata = {7'd0, head.parse_failed, head.field_end,
                      head.field_begin, head.column_number};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

### tb/dsv_line_field_tokenizer_core_tb.sv
// ============================================================================
// dsv_line_field_tokenizer_core_tb
// Self-checking testbench for the delimited-text line field tokenizer.
// ----------------------------------------------------------------------------
// Drives lines one byte per beat, each closed by an end-of-line beat.
// A scoreboard class keeps its own copy of the line state and registers.
// It works out the field, line-done and comment results of every accepted
// beat and compares them in order with the result stream.
// Stimulus starts with hand-picked lines: an empty line, a comment, quoted
// fields with escaped quotes and stray quotes, and extreme byte values.
// Random lines then run under several register settings, and one overlong
// line runs through truncation. Sender bursts, receiver stall patterns and
// a long receiver hold-off exercise the back-pressure paths.
// ============================================================================
module dsv_line_field_tokenizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [dlt_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  DRAIN_CYCLES = 4;
    localparam int  CYCLE_LIMIT  = 4000000;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the result beats of each accepted input beat
    // ------------------------------------------------------------------------
    class token_scoreboard;
        // register copies
        logic [7:0]  delim;
        logic [15:0] exp_cols;
        logic        stop_cmt;
        // line state
        logic [15:0] pos, col, fbeg, fend;
        logic        in_q, q_pend, closed, q_ok, trunc, cmt;

        dlt_pkg::result_t pending_tokens[$];
        int          mismatches, n_checked, n_fields, n_lines, n_comments;

        function new();
            delim      = 8'd44;
            exp_cols   = 16'd0;
            stop_cmt   = 1'b1;
            mismatches = 0;
            n_checked  = 0;
            n_fields   = 0;
            n_lines    = 0;
            n_comments = 0;
            clear_line();
        endfunction

        function void clear_line();
            pos    = '0;
            col    = '0;
            fbeg   = '0;
            fend   = '0;
            in_q   = 1'b0;
            q_pend = 1'b0;
            closed = 1'b0;
            q_ok   = 1'b1;
            trunc  = 1'b0;
            cmt    = 1'b0;
        endfunction

        function void write_reg(logic [dlt_pkg::CFG_ADDR_W-1:0] idx, logic [15:0] val);
            case (idx)
                dlt_pkg::REG_DELIMITER:        delim    = val[7:0];
                dlt_pkg::REG_EXPECTED_COLUMNS: exp_cols = val;
                dlt_pkg::REG_STOP_ON_COMMENT:  stop_cmt = val[0];
                default: ;
            endcase
        endfunction

        function void queue_token(dlt_pkg::kind_t k, logic [15:0] c, logic [15:0] fb,
                                  logic [15:0] fe, logic f, logic l);
            dlt_pkg::result_t r;
            r.kind          = k;
            r.column_number = c;
            r.field_begin   = fb;
            r.field_end     = fe;
            r.parse_failed  = f;
            r.last          = l;
            pending_tokens.insert(pending_tokens.size(), r);
            if (k == dlt_pkg::KIND_FIELD)
                n_fields++;
            else if (k == dlt_pkg::KIND_LINE_DONE)
                n_lines++;
            else
                n_comments++;
        endfunction

        // one accepted input beat
        function void predict_tokens(logic act, logic [7:0] b);
            logic [15:0] p;
            logic        esc;
            logic        fail;
            if (act == dlt_pkg::ACT_EOL) begin
                if (cmt) begin
                    queue_token(stop_cmt ? dlt_pkg::KIND_COMMENT_STOP
                                         : dlt_pkg::KIND_COMMENT_SKIP,
                                '0, '0, '0, 1'b0, 1'b1);
                end else begin
                    fail = trunc;
                    if (fbeg != fend)
                        queue_token(dlt_pkg::KIND_FIELD, col, fbeg, fend, 1'b0, 1'b0);
                    // column count check is 17 bits wide
                    if (exp_cols != 0 && ({1'b0, col} + 17'd1) != {1'b0, exp_cols})
                        fail = 1'b1;
                    queue_token(dlt_pkg::KIND_LINE_DONE, col, '0, '0, fail, 1'b1);
                end
                clear_line();
                return;
            end

            if (cmt || trunc)
                return;
            if (pos == 0 && b == dlt_pkg::HASH_BYTE) begin
                cmt = 1'b1;
                return;
            end

            p   = pos;
            esc = 1'b0;
            // a held quote is settled by the byte after it
            if (q_pend) begin
                q_pend = 1'b0;
                if (b == dlt_pkg::QUOTE_BYTE) begin
                    esc = 1'b1;
                end else begin
                    in_q   = 1'b0;
                    closed = 1'b1;
                end
            end

            if (!esc) begin
                if (b == dlt_pkg::QUOTE_BYTE) begin
                    if (q_ok && !in_q) begin
                        in_q = 1'b1;
                        fbeg = p + 16'd1;
                        fend = p + 16'd1;
                    end else if (in_q) begin
                        q_pend = 1'b1;
                    end
                end else if (!in_q && b == delim) begin
                    if (fbeg != fend)
                        queue_token(dlt_pkg::KIND_FIELD, col, fbeg, fend, 1'b0, 1'b1);
                    closed = 1'b0;
                    q_ok   = 1'b1;
                    col    = col + 16'd1;
                    fbeg   = p + 16'd1;
                    fend   = p + 16'd1;
                end else if (!closed) begin
                    q_ok = 1'b0;
                    fend = p + 16'd1;
                end
            end

            if (p >= dlt_pkg::TRUNC_POS)
                trunc = 1'b1;
            pos = p + 16'd1;
        endfunction

        // one accepted result beat against the oldest prediction
        function void check_token(dlt_pkg::result_t got);
            dlt_pkg::result_t want;
            n_checked++;
            if (pending_tokens.size() == 0) begin
                $error("unexpected result beat: kind %0d column %0d",
                       got.kind, got.column_number);
                mismatches++;
                return;
            end
            want = pending_tokens.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                mismatches++;
            end
            if (got.column_number !== want.column_number) begin
                $error("column_number: expected %0d, got %0d",
                       want.column_number, got.column_number);
                mismatches++;
            end
            if (got.field_begin !== want.field_begin) begin
                $error("field_begin: expected %0d, got %0d",
                       want.field_begin, got.field_begin);
                mismatches++;
            end
            if (got.field_end !== want.field_end) begin
                $error("field_end: expected %0d, got %0d",
                       want.field_end, got.field_end);
                mismatches++;
            end
            if (got.parse_failed !== want.parse_failed) begin
                $error("parse_failed: expected %0d, got %0d",
                       want.parse_failed, got.parse_failed);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block
    // ------------------------------------------------------------------------
    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;
    logic [0:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [55:0]                    m_tdata;
    logic [1:0]                     m_tuser;
    logic                           m_tlast;
    logic                           cfg_wr_en;
    logic [dlt_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [dlt_pkg::CFG_DATA_W-1:0] cfg_wdata;

    token_scoreboard       sb;
    logic [7:0]            line_bytes[$];
    int                    burst_left;
    int                    cycles;
    int                    in_stall_cycles;
    int                    settings_run;
    logic                  hold_req;

    dsv_line_field_tokenizer_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Result monitor, sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        dlt_pkg::result_t got;
        if (aresetn) begin
            if (s_tvalid && !s_tready)
                in_stall_cycles++;
            if (m_tvalid && m_tready) begin
                got.kind          = dlt_pkg::kind_t'(m_tuser);
                got.column_number = m_tdata[15:0];
                got.field_begin   = m_tdata[31:16];
                got.field_end     = m_tdata[47:32];
                got.parse_failed  = m_tdata[48];
                got.last          = m_tlast;
                sb.check_token(got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall density changes per stretch; long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int seg;
        int dens;
        m_tready = 1'b0;
        seg      = 0;
        dens     = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                if (seg == 0) begin
                    seg  = $urandom_range(10, 120);
                    dens = $urandom_range(0, 3);
                end
                seg--;
                m_tready <= ($urandom_range(0, 3) >= dens);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $error("timeout after %0d cycles, %0d results still outstanding",
               cycles, sb.pending_tokens.size());
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drive tasks
    // ------------------------------------------------------------------------

    // one input beat; the sender runs in bursts with random gaps
    task automatic send_item(input logic act, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 6);
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.predict_tokens(act, b);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(dlt_pkg::ACT_BYTE, s[i]);
        send_item(dlt_pkg::ACT_EOL, 8'h00);
    endtask

    // drop valid and wait until every predicted result is back
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending_tokens.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [dlt_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // new register setting; upper bits of narrow registers carry junk
    task automatic set_regs(input logic [7:0] d, input logic [15:0] cols, input logic stop);
        write_reg(dlt_pkg::REG_DELIMITER, {8'($urandom), d});
        write_reg(dlt_pkg::REG_EXPECTED_COLUMNS, cols);
        write_reg(dlt_pkg::REG_STOP_ON_COMMENT, {15'($urandom), stop});
        settings_run++;
    endtask

    // adds one byte at the end of the line being built
    function automatic void append_byte(input logic [7:0] b);
        line_bytes.insert(line_bytes.size(), b);
    endfunction

    function automatic logic [7:0] plain_byte(input logic [7:0] d);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == dlt_pkg::QUOTE_BYTE || b == d);
        return b;
    endfunction

    // builds one random line into line_bytes; returns 1 for a comment line
    function automatic bit build_line(input logic [7:0] d);
        int nf, k, n, j;
        line_bytes.delete();
        // comment line
        if ($urandom_range(0, 11) == 0) begin
            append_byte(dlt_pkg::HASH_BYTE);
            n = $urandom_range(0, 6);
            repeat (n) append_byte(8'($urandom_range(0, 255)));
            return 1'b1;
        end
        // noise, biased toward quotes and delimiters
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) begin
                case ($urandom_range(0, 3))
                    0:       append_byte(dlt_pkg::QUOTE_BYTE);
                    1:       append_byte(d);
                    default: append_byte(8'($urandom_range(0, 255)));
                endcase
            end
            return 1'b0;
        end
        // well-formed fields with random content
        nf = $urandom_range(1, 6);
        for (k = 0; k < nf; k++) begin
            if (k != 0)
                append_byte(d);
            case ($urandom_range(0, 4))
                0: ;    // empty field
                1, 2: begin
                    n = $urandom_range(1, 4);
                    repeat (n) append_byte(plain_byte(d));
                end
                3: begin
                    append_byte(dlt_pkg::QUOTE_BYTE);
                    n = $urandom_range(0, 4);
                    for (j = 0; j < n; j++) begin
                        case ($urandom_range(0, 3))
                            0: append_byte(d);
                            1: begin
                                append_byte(dlt_pkg::QUOTE_BYTE);
                                append_byte(dlt_pkg::QUOTE_BYTE);
                            end
                            default: append_byte(plain_byte(d));
                        endcase
                    end
                    // unterminated quote on the last field now and then
                    if (k != nf - 1 || $urandom_range(0, 5) != 0)
                        append_byte(dlt_pkg::QUOTE_BYTE);
                    // junk after the closing quote
                    if ($urandom_range(0, 3) == 0)
                        append_byte(plain_byte(d));
                end
                default: begin
                    // stray quote inside unquoted data
                    append_byte(plain_byte(d));
                    append_byte(dlt_pkg::QUOTE_BYTE);
                    append_byte(plain_byte(d));
                end
            endcase
        end
        return 1'b0;
    endfunction

    task automatic run_random(input int n_items, input bit with_hold);
        int  sent;
        bit  held;
        bit  is_cmt;
        int  i;
        sent = 0;
        held = 1'b0;
        while (sent < n_items) begin
            if (with_hold && !held && sent >= n_items / 3) begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            is_cmt = build_line(sb.delim);
            for (i = 0; i < line_bytes.size(); i++)
                send_item(dlt_pkg::ACT_BYTE, line_bytes[i]);
            send_item(dlt_pkg::ACT_EOL, 8'($urandom_range(0, 255)));
            sent += is_cmt ? 1 : line_bytes.size() + 1;
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // runs past the length limit: mostly delimiters, a few one-byte fields
    task automatic send_long_line();
        int k;
        for (k = 0; k < dlt_pkg::MAX_LINE_BYTES + 2; k++)
            send_item(dlt_pkg::ACT_BYTE, ($urandom_range(0, 7) != 0) ? sb.delim : 8'h78);
        send_item(dlt_pkg::ACT_EOL, 8'hFF);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb              = new();
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        cfg_wr_en       = 1'b0;
        cfg_addr        = '0;
        cfg_wdata       = '0;
        hold_req        = 1'b0;
        burst_left      = 0;
        in_stall_cycles = 0;
        settings_run    = 0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed lines with the default comma
        set_regs(8'd44, 16'd0, 1'b1);
        send_item(dlt_pkg::ACT_EOL, 8'h00);     // empty line
        send_text("#a");                        // comment, stop mode
        send_text("a,\"b,\"\"\",,c\"d");        // quoting, escape, empty, stray
        send_text("\"x\"y");                    // junk after closing quote
        send_item(dlt_pkg::ACT_BYTE, 8'h00);
        send_item(dlt_pkg::ACT_BYTE, 8'hFF);
        send_item(dlt_pkg::ACT_EOL, 8'h00);
        wait_drained();

        // random lines under several settings
        set_regs(8'd44, 16'd3, 1'b0);
        run_random(130, 1'b1);

        set_regs(8'h00, 16'd0, 1'b1);
        run_random(110, 1'b0);

        set_regs(8'hFF, 16'hFFFF, 1'b0);
        write_reg(REG_UNUSED, 16'($urandom));
        run_random(110, 1'b0);

        // delimiter equal to the quote byte
        set_regs(dlt_pkg::QUOTE_BYTE, 16'd1, 1'b1);
        run_random(100, 1'b0);

        set_regs(8'($urandom_range(0, 255)), 16'($urandom_range(0, 6)),
                 1'($urandom_range(0, 1)));
        run_random(130, 1'b0);

        // tab delimiter, overlong line, then more random lines
        set_regs(8'h09, 16'd2, 1'b0);
        send_long_line();
        run_random(70, 1'b0);

        wait_drained();
        repeat (8) @(posedge aclk);

        $display("Covered %0d lines, %0d fields and %0d comment lines under %0d settings;",
                 sb.n_lines, sb.n_fields, sb.n_comments, settings_run);
        $display("%0d result beats checked, input held off on %0d cycles.",
                 sb.n_checked, in_stall_cycles);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
